// ----- design/tsd_pkg.sv -----
// Package for timestamp_difference: timestamp record type, calendar constants,
// reciprocal constants and the table of days before each month.
// Depends on nothing.
`timescale 1ns / 1ps

package tsd_pkg;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} ts_t;

	localparam int unsigned HOURS_PER_YEAR = 8760;
	localparam int unsigned HOURS_PER_DAY  = 24;
	localparam int unsigned SECS_PER_MIN   = 60;
	localparam int unsigned SECS_PER_HOUR  = 3600;
	localparam int unsigned CENT_DIV       = 25;

	// floor(x / 25) = (x * RECIP_25) >> 16 for x below 4096
	localparam int unsigned RECIP_25       = 2622;
	localparam int unsigned RECIP_25_SHIFT = 16;
	// floor(x / 60) = (x * RECIP_60) >> 18 for x below 3600
	localparam int unsigned RECIP_60       = 4370;
	localparam int unsigned RECIP_60_SHIFT = 18;

	localparam logic [3:0] MONTH_MARCH = 4'd3;

	// days of past months in a common year; months above twelve take the whole year
	function automatic logic [8:0] cum_days(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd0, 4'd1: d = 9'd0;
			4'd2:       d = 9'd31;
			4'd3:       d = 9'd59;
			4'd4:       d = 9'd90;
			4'd5:       d = 9'd120;
			4'd6:       d = 9'd151;
			4'd7:       d = 9'd181;
			4'd8:       d = 9'd212;
			4'd9:       d = 9'd243;
			4'd10:      d = 9'd273;
			4'd11:      d = 9'd304;
			4'd12:      d = 9'd334;
			default:    d = 9'd365;
		endcase
		return d;
	endfunction

endpackage

// ----- design/timestamp_difference.sv -----
// timestamp_difference: absolute difference of two Gregorian timestamps as hours,
// minutes and seconds. Seven-stage pipeline, uses tsd_pkg.
// One transfer per cycle sustained; a stall on the output holds the full stages
// from the output back to the first empty stage, while the stages behind it
// still advance, and in_stall rises only when all seven stages are full.
// Reset clears the stage valid bits only; data registers are not reset.
`timescale 1ns / 1ps

module timestamp_difference
	import tsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [13:0] year_a,
	input  logic [3:0]  month_a,
	input  logic [4:0]  day_a,
	input  logic [4:0]  hour_a,
	input  logic [5:0]  minute_a,
	input  logic [5:0]  second_a,
	input  logic [13:0] year_b,
	input  logic [3:0]  month_b,
	input  logic [4:0]  day_b,
	input  logic [4:0]  hour_b,
	input  logic [5:0]  minute_b,
	input  logic [5:0]  second_b,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [26:0] diff_hours,
	output logic [5:0]  diff_minutes,
	output logic [5:0]  diff_seconds
);

	ts_t in_ts [2];

	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6, valid_s7;
	logic en1, en2, en3, en4, en5, en6, en7;

	// stage 1 combinational
	logic signed [14:0] py_c      [2];
	logic        [13:0] pyu_c     [2];
	logic        [23:0] p100_c    [2];
	logic        [21:0] p400_c    [2];
	logic        [23:0] yp100_c   [2];
	logic        [21:0] yp400_c   [2];
	logic signed [28:0] pyh_c     [2];
	logic        [11:0] secs_c    [2];

	// stage 1 registers
	logic signed [28:0] pyh_s1    [2];
	logic        [11:0] q4_s1     [2];
	logic        [7:0]  q100_s1   [2];
	logic        [5:0]  q400_s1   [2];
	logic        [7:0]  yq100_s1  [2];
	logic        [5:0]  yq400_s1  [2];
	logic        [13:0] year_s1   [2];
	logic        [3:0]  month_s1  [2];
	logic        [4:0]  day_s1    [2];
	logic        [4:0]  hour_s1   [2];
	logic        [11:0] secs_s1   [2];

	// stage 2
	logic               leap_c    [2];
	logic        [11:0] leaps_c   [2];
	logic signed [13:0] days_c    [2];
	logic signed [13:0] days_s2   [2];
	logic signed [28:0] pyh_s2    [2];
	logic        [4:0]  hour_s2   [2];
	logic        [11:0] secs_s2   [2];

	// stage 3
	logic signed [28:0] hrs_c     [2];
	logic signed [28:0] hrs_s3    [2];
	logic        [13:0] dsec_c;
	logic        [1:0]  carry_c;
	logic        [11:0] rem_c;
	logic        [1:0]  carry_s3;
	logic        [11:0] rem_s3;

	// stage 4
	logic signed [29:0] dh_s4;
	logic        [11:0] rem_s4;

	// stage 5
	logic        [29:0] mag_c;
	logic        [26:0] hours_s5;
	logic        [11:0] rem_s5;

	// stage 6
	logic        [24:0] pmin_c;
	logic        [26:0] hours_s6;
	logic        [11:0] rem_s6;
	logic        [5:0]  min_s6;

	// stage 7
	logic        [11:0] sec_c;
	logic        [26:0] hours_s7;
	logic        [5:0]  min_s7;
	logic        [5:0]  sec_s7;

	assign in_ts[0] = '{year_a, month_a, day_a, hour_a, minute_a, second_a};
	assign in_ts[1] = '{year_b, month_b, day_b, hour_b, minute_b, second_b};

	assign en7 = !valid_s7 || !out_stall;
	assign en6 = !valid_s6 || en7;
	assign en5 = !valid_s5 || en6;
	assign en4 = !valid_s4 || en5;
	assign en3 = !valid_s3 || en4;
	assign en2 = !valid_s2 || en3;
	assign en1 = !valid_s1 || en2;
	assign in_stall = !en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (en1) valid_s1 <= in_valid;
			if (en2) valid_s2 <= valid_s1;
			if (en3) valid_s3 <= valid_s2;
			if (en4) valid_s4 <= valid_s3;
			if (en5) valid_s5 <= valid_s4;
			if (en6) valid_s6 <= valid_s5;
			if (en7) valid_s7 <= valid_s6;
		end
	end

	// stage 1: past years in hours, quotients by 25 for the century terms, seconds in the hour
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			py_c[i]    = 15'({1'b0, in_ts[i].year}) - 15'sd1;
			pyu_c[i]   = in_ts[i].year - 14'd1;
			p100_c[i]  = 24'(pyu_c[i][13:2]) * 24'(RECIP_25);
			p400_c[i]  = 22'(pyu_c[i][13:4]) * 22'(RECIP_25);
			yp100_c[i] = 24'(in_ts[i].year[13:2]) * 24'(RECIP_25);
			yp400_c[i] = 22'(in_ts[i].year[13:4]) * 22'(RECIP_25);
			pyh_c[i]   = 29'(py_c[i]) * 29'(HOURS_PER_YEAR);
			secs_c[i]  = 12'(in_ts[i].minute) * 12'(SECS_PER_MIN) + 12'(in_ts[i].second);
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < 2; i++) begin
				pyh_s1[i]   <= pyh_c[i];
				q4_s1[i]    <= pyu_c[i][13:2];
				q100_s1[i]  <= p100_c[i][RECIP_25_SHIFT +: 8];
				q400_s1[i]  <= p400_c[i][RECIP_25_SHIFT +: 6];
				yq100_s1[i] <= yp100_c[i][RECIP_25_SHIFT +: 8];
				yq400_s1[i] <= yp400_c[i][RECIP_25_SHIFT +: 6];
				year_s1[i]  <= in_ts[i].year;
				month_s1[i] <= in_ts[i].month;
				day_s1[i]   <= in_ts[i].day;
				hour_s1[i]  <= in_ts[i].hour;
				secs_s1[i]  <= secs_c[i];
			end
		end
	end

	// stage 2: leap flag, past leap days, past days of the year
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			leap_c[i] = ((year_s1[i][1:0] == 2'd0) &&
				(12'(yq100_s1[i]) * 12'(CENT_DIV) != year_s1[i][13:2])) ||
				((year_s1[i][3:0] == 4'd0) &&
				(10'(yq400_s1[i]) * 10'(CENT_DIV) == year_s1[i][13:4]));
			leaps_c[i] = (year_s1[i] == 14'd0) ? 12'd0 :
				q4_s1[i] - 12'(q100_s1[i]) + 12'(q400_s1[i]);
			days_c[i] = 14'(leaps_c[i]) + 14'(cum_days(month_s1[i])) +
				14'(leap_c[i] && (month_s1[i] >= MONTH_MARCH)) +
				14'(day_s1[i]) - 14'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			for (int i = 0; i < 2; i++) begin
				days_s2[i] <= days_c[i];
				pyh_s2[i]  <= pyh_s1[i];
				hour_s2[i] <= hour_s1[i];
				secs_s2[i] <= secs_s1[i];
			end
		end
	end

	// stage 3: hours since epoch; second difference normalized into one hour
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			hrs_c[i] = pyh_s2[i] + 29'(days_s2[i]) * 29'(HOURS_PER_DAY) +
				29'(hour_s2[i]);
		end
		dsec_c = 14'(secs_s2[0]) - 14'(secs_s2[1]) + 14'(2 * SECS_PER_HOUR);
		priority if (dsec_c >= 14'(3 * SECS_PER_HOUR)) begin
			carry_c = 2'd3;
		end else if (dsec_c >= 14'(2 * SECS_PER_HOUR)) begin
			carry_c = 2'd2;
		end else if (dsec_c >= 14'(SECS_PER_HOUR)) begin
			carry_c = 2'd1;
		end else begin
			carry_c = 2'd0;
		end
		rem_c = 12'(dsec_c - 14'(carry_c) * 14'(SECS_PER_HOUR));
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			hrs_s3   <= hrs_c;
			carry_s3 <= carry_c;
			rem_s3   <= rem_c;
		end
	end

	// stage 4: signed hour difference with the seconds carry
	always_ff @(posedge clk) begin
		if (en4) begin
			dh_s4  <= 30'(hrs_s3[0]) - 30'(hrs_s3[1]) + 30'(carry_s3) - 30'sd2;
			rem_s4 <= rem_s3;
		end
	end

	// stage 5: absolute value, borrow an hour when negative with seconds left
	always_comb begin
		if (dh_s4[29]) begin
			mag_c = (rem_s4 == 12'd0) ? 30'(-dh_s4) : ~30'(dh_s4);
		end else begin
			mag_c = 30'(dh_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (en5) begin
			hours_s5 <= mag_c[26:0];
			rem_s5   <= (dh_s4[29] && rem_s4 != 12'd0) ?
				12'(SECS_PER_HOUR) - rem_s4 : rem_s4;
		end
	end

	// stage 6: minutes by reciprocal
	assign pmin_c = 25'(rem_s5) * 25'(RECIP_60);

	always_ff @(posedge clk) begin
		if (en6) begin
			hours_s6 <= hours_s5;
			rem_s6   <= rem_s5;
			min_s6   <= pmin_c[RECIP_60_SHIFT +: 6];
		end
	end

	// stage 7: seconds left over, output register
	assign sec_c = rem_s6 - 12'(min_s6) * 12'(SECS_PER_MIN);

	always_ff @(posedge clk) begin
		if (en7) begin
			hours_s7 <= hours_s6;
			min_s7   <= min_s6;
			sec_s7   <= sec_c[5:0];
		end
	end

	assign out_valid    = valid_s7;
	assign diff_hours   = hours_s7;
	assign diff_minutes = min_s7;
	assign diff_seconds = sec_s7;

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (diff_minutes < 6'd60) && (diff_seconds < 6'd60))
		else $error("result minutes or seconds out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && valid_s3 && valid_s4 &&
			valid_s5 && valid_s6 && valid_s7 && out_stall)
		else $error("input stalled while pipeline has a free stage");

	a_norm_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> rem_s3 < 12'(SECS_PER_HOUR))
		else $error("second difference not normalized");

	a_abs_rem: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s5 |-> rem_s5 < 12'(SECS_PER_HOUR))
		else $error("remainder after borrow out of range");

	a_min_div: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> (12'(min_s6) * 12'(SECS_PER_MIN) <= rem_s6) &&
			(sec_c < 12'(SECS_PER_MIN)))
		else $error("minute quotient wrong");

endmodule

// ----- verif/timestamp_difference_checker.sv -----
// Checker for timestamp_difference: watches both channels, predicts each result
// from the input transfer and compares it field by field. Uses tsd_pkg for ts_t.
`timescale 1ns / 1ps

module timestamp_difference_checker
	import tsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [13:0] year_a,
	input  logic [3:0]  month_a,
	input  logic [4:0]  day_a,
	input  logic [4:0]  hour_a,
	input  logic [5:0]  minute_a,
	input  logic [5:0]  second_a,
	input  logic [13:0] year_b,
	input  logic [3:0]  month_b,
	input  logic [4:0]  day_b,
	input  logic [4:0]  hour_b,
	input  logic [5:0]  minute_b,
	input  logic [5:0]  second_b,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [26:0] diff_hours,
	input  logic [5:0]  diff_minutes,
	input  logic [5:0]  diff_seconds,
	output int          errors,
	output int          pending
);

	typedef struct packed {
		logic [26:0] hours;
		logic [5:0]  minutes;
		logic [5:0]  seconds;
	} span_t;

	span_t span_q[$];

	function automatic longint epoch_seconds(input ts_t t);
		longint y;
		longint py;
		longint leaps;
		longint hrs;
		bit     leap;
		int     mo;
		int     j;
		y     = longint'(t.year);
		mo    = int'(t.month);
		py    = y - 1;
		leaps = py / 4 - py / 100 + py / 400;
		hrs   = py * 8760 + leaps * 24;
		leap  = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		for (j = 1; j < mo && j <= 12; j++) begin
			if (j == 2)
				hrs += leap ? 29 * 24 : 28 * 24;
			else if (j == 4 || j == 6 || j == 9 || j == 11)
				hrs += 30 * 24;
			else
				hrs += 31 * 24;
		end
		hrs += (longint'(t.day) - 1) * 24 + longint'(t.hour);
		return hrs * 3600 + longint'(t.minute) * 60 + longint'(t.second);
	endfunction

	function automatic span_t span_between(input ts_t a, input ts_t b);
		longint sa;
		longint sb;
		longint gap;
		span_t  r;
		sa        = epoch_seconds(a);
		sb        = epoch_seconds(b);
		gap       = (sa >= sb) ? sa - sb : sb - sa;
		r.hours   = 27'(gap / 3600);
		r.minutes = 6'((gap % 3600) / 60);
		r.seconds = 6'(gap % 60);
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		errors++;
	endtask

	always @(posedge clk) begin
		span_t want;
		if (!arst_n) begin
			span_q.delete();
			pending <= 0;
		end else begin
			if (in_valid && !in_stall)
				span_q.push_back(span_between(
					{year_a, month_a, day_a, hour_a, minute_a, second_a},
					{year_b, month_b, day_b, hour_b, minute_b, second_b}));
			if (out_valid && !out_stall) begin
				if (span_q.size() == 0) begin
					report_mismatch("result transfer with no expectation pending");
				end else begin
					want = span_q.pop_front();
					if (diff_hours !== want.hours)
						report_mismatch($sformatf("diff_hours got %0d want %0d",
							diff_hours, want.hours));
					if (diff_minutes !== want.minutes)
						report_mismatch($sformatf("diff_minutes got %0d want %0d",
							diff_minutes, want.minutes));
					if (diff_seconds !== want.seconds)
						report_mismatch($sformatf("diff_seconds got %0d want %0d",
							diff_seconds, want.seconds));
				end
			end
			pending <= span_q.size();
		end
	end

endmodule

// ----- verif/timestamp_difference_test.sv -----
// Testbench top for timestamp_difference: clock, reset, directed and random
// timestamp pairs with random idling on both sides, and the verdict.
// Depends on tsd_pkg, timestamp_difference and timestamp_difference_checker.
`timescale 1ns / 1ps

module timestamp_difference_test;
	import tsd_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [13:0] year_a;
	logic [3:0]  month_a;
	logic [4:0]  day_a;
	logic [4:0]  hour_a;
	logic [5:0]  minute_a;
	logic [5:0]  second_a;
	logic [13:0] year_b;
	logic [3:0]  month_b;
	logic [4:0]  day_b;
	logic [4:0]  hour_b;
	logic [5:0]  minute_b;
	logic [5:0]  second_b;
	logic        out_valid;
	logic        out_stall;
	logic [26:0] diff_hours;
	logic [5:0]  diff_minutes;
	logic [5:0]  diff_seconds;
	int          errors;
	int          pending;
	int          send_idle_pct;
	int          stall_pct;

	timestamp_difference DUT (
		.clk, .arst_n, .in_valid, .in_stall,
		.year_a, .month_a, .day_a, .hour_a, .minute_a, .second_a,
		.year_b, .month_b, .day_b, .hour_b, .minute_b, .second_b,
		.out_valid, .out_stall, .diff_hours, .diff_minutes, .diff_seconds
	);

	timestamp_difference_checker checker_i (
		.clk, .arst_n, .in_valid, .in_stall,
		.year_a, .month_a, .day_a, .hour_a, .minute_a, .second_a,
		.year_b, .month_b, .day_b, .hour_b, .minute_b, .second_b,
		.out_valid, .out_stall, .diff_hours, .diff_minutes, .diff_seconds,
		.errors, .pending
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic ts_t stamp(input int y, input int mo, input int d,
			input int h, input int mi, input int s);
		ts_t t;
		t.year   = 14'(y);
		t.month  = 4'(mo);
		t.day    = 5'(d);
		t.hour   = 5'(h);
		t.minute = 6'(mi);
		t.second = 6'(s);
		return t;
	endfunction

	function automatic ts_t calendar_stamp();
		return stamp($urandom_range(9999, 1), $urandom_range(12, 1), $urandom_range(31, 1),
			$urandom_range(23), $urandom_range(59), $urandom_range(59));
	endfunction

	function automatic ts_t raw_stamp();
		return stamp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
	endfunction

	task automatic send_pair(input ts_t a, input ts_t b);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		year_a   <= a.year;
		month_a  <= a.month;
		day_a    <= a.day;
		hour_a   <= a.hour;
		minute_a <= a.minute;
		second_a <= a.second;
		year_b   <= b.year;
		month_b  <= b.month;
		day_b    <= b.day;
		hour_b   <= b.hour;
		minute_b <= b.minute;
		second_b <= b.second;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	task automatic send_random_pair();
		ts_t a;
		ts_t b;
		int  mode;
		mode = $urandom_range(99);
		a = calendar_stamp();
		if (mode < 45) begin
			b = calendar_stamp();
		end else if (mode < 70) begin
			// same year and month, new time of day and sometimes a new day
			b = a;
			b.hour   = 5'($urandom_range(23));
			b.minute = 6'($urandom_range(59));
			b.second = 6'($urandom_range(59));
			if ($urandom_range(1))
				b.day = 5'($urandom_range(31, 1));
		end else if (mode < 80) begin
			b = a;
			case ($urandom_range(5))
				0: b.year   = 14'($urandom_range(9999, 1));
				1: b.month  = 4'($urandom_range(12, 1));
				2: b.day    = 5'($urandom_range(31, 1));
				3: b.hour   = 5'($urandom_range(23));
				4: b.minute = 6'($urandom_range(59));
				default: b.second = 6'($urandom_range(59));
			endcase
		end else if (mode < 90) begin
			a = raw_stamp();
			b = raw_stamp();
		end else begin
			b = raw_stamp();
		end
		if ($urandom_range(1))
			send_pair(a, b);
		else
			send_pair(b, a);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		out_stall     = 1'b0;
		year_a        = '0;
		month_a       = '0;
		day_a         = '0;
		hour_a        = '0;
		minute_a      = '0;
		second_a      = '0;
		year_b        = '0;
		month_b       = '0;
		day_b         = '0;
		hour_b        = '0;
		minute_b      = '0;
		second_b      = '0;
		send_idle_pct = 28;
		stall_pct     = 63;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pair(stamp(2023, 6, 15, 12, 30, 45), stamp(2023, 6, 15, 12, 30, 45));
		send_pair(stamp(1, 1, 1, 0, 0, 0), stamp(9999, 12, 31, 23, 59, 59));
		send_pair(stamp(9999, 12, 31, 23, 59, 59), stamp(1, 1, 1, 0, 0, 0));
		send_pair(stamp(0, 3, 1, 0, 0, 0), stamp(1, 1, 1, 0, 0, 0));
		send_pair(stamp(0, 0, 0, 0, 0, 0), stamp(16383, 15, 31, 31, 63, 63));
		send_pair(stamp(16383, 15, 31, 31, 63, 63), stamp(16383, 15, 31, 31, 63, 63));
		send_pair(stamp(0, 0, 0, 0, 0, 0), stamp(0, 0, 0, 0, 0, 0));
		send_pair(stamp(2000, 3, 1, 0, 0, 0), stamp(1900, 3, 1, 0, 0, 0));
		send_pair(stamp(2024, 2, 29, 23, 0, 0), stamp(2024, 3, 1, 0, 0, 0));
		send_pair(stamp(2023, 13, 1, 0, 0, 0), stamp(2024, 1, 1, 0, 0, 0));
		send_pair(stamp(2023, 14, 1, 0, 0, 0), stamp(2023, 15, 1, 0, 0, 0));
		send_pair(stamp(2023, 0, 5, 0, 0, 0), stamp(2023, 1, 5, 0, 0, 0));
		send_pair(stamp(2023, 5, 0, 0, 0, 0), stamp(2023, 4, 30, 0, 0, 0));
		send_pair(stamp(2023, 2, 31, 0, 0, 0), stamp(2023, 3, 3, 0, 0, 0));
		send_pair(stamp(2023, 6, 1, 0, 0, 0), stamp(2023, 6, 1, 0, 63, 63));
		send_pair(stamp(2023, 6, 1, 10, 0, 0), stamp(2023, 6, 1, 9, 59, 59));
		send_pair(stamp(2023, 6, 1, 31, 0, 0), stamp(2023, 6, 2, 7, 0, 1));
		send_pair(stamp(1600, 2, 29, 0, 0, 0), stamp(2400, 2, 29, 0, 0, 0));
		send_pair(stamp(8191, 8, 16, 16, 32, 32), stamp(8192, 7, 15, 15, 31, 31));
		drain();

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 28 : (phase == 1) ? 63 : 0;
			stall_pct     = (phase == 0) ? 63 : (phase == 1) ? 28 : 0;
			repeat (400) send_random_pair();
		end

		drain();
		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#1000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
design/tsd_pkg.sv
design/timestamp_difference.sv
verif/timestamp_difference_checker.sv
verif/timestamp_difference_test.sv
